/* design/frlpm_pkg.sv */
package frlpm_pkg;

	// Field widths
	localparam int unsigned ADDR_W    = 24;
	localparam int unsigned LEN_W     = 13;
	localparam int unsigned CNT_W     = 17;
	localparam int unsigned RFB_W     = 8;
	localparam int unsigned RBC_W     = 5;
	localparam int unsigned CFG_W     = 17;
	localparam int unsigned CFG_IDX_W = 2;

	// Flash geometry, all powers of two
	localparam int unsigned RECORD_BYTES      = 16;
	localparam int unsigned BLOCK_BYTES       = 65536;
	localparam int unsigned RECORDS_PER_BLOCK = 4096;
	localparam int unsigned REC_SHIFT   = $clog2(RECORD_BYTES);
	localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int unsigned RPB_SHIFT   = $clog2(RECORDS_PER_BLOCK);

	// Block index math: wide enough for first + count and for pointer block + 1
	localparam int unsigned NXT_W = (ADDR_W - BLOCK_SHIFT + 1 > RFB_W + 1) ?
		ADDR_W - BLOCK_SHIFT + 1 : RFB_W + 1;
	// Records between region start and pointer
	localparam int unsigned FF_W   = ADDR_W - REC_SHIFT;
	localparam int unsigned CF_W   = ((FF_W > CNT_W) ? FF_W : CNT_W) + 1;
	localparam int unsigned TRIM_W = (RBC_W + RPB_SHIFT > CNT_W) ? RBC_W + RPB_SHIFT : CNT_W;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Queue depths
	localparam int unsigned CMD_DEPTH_DEF = 2;
	localparam int unsigned RES_DEPTH_DEF = 2;

	// Register reset values and indexes
	localparam logic [RFB_W-1:0] RFB_RESET = 8'd0;
	localparam logic [RBC_W-1:0] RBC_RESET = 5'd4;
	localparam logic [CNT_W-1:0] MAX_RESET = 17'd12288;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_BLOCK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_READABLE = 2'd2;

	// Command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	// Flash operation codes
	localparam logic [1:0] OP_NONE    = 2'd0;
	localparam logic [1:0] OP_PROGRAM = 2'd1;
	localparam logic [1:0] OP_ERASE   = 2'd2;
	localparam logic [1:0] OP_READ    = 2'd3;

	typedef enum logic [1:0] {
		KIND_STATUS,
		KIND_WRITE,
		KIND_READ,
		KIND_CLEAR
	} kind_t;

	typedef struct packed {
		logic [1:0]       command;
		logic             record_is_empty;
		logic [CNT_W-1:0] first_index;
		logic [LEN_W-1:0] read_count;
	} item_t;

	typedef struct packed {
		logic [1:0]        flash_op;
		logic [ADDR_W-1:0] flash_address;
		logic [LEN_W-1:0]  op_length;
		logic [CNT_W-1:0]  stored_count;
		logic              last;
	} result_t;

	typedef struct packed {
		kind_t            kind;
		logic [CNT_W-1:0] first_index;
		logic [LEN_W-1:0] read_count;
	} cmd_t;

	typedef struct packed {
		logic [RFB_W-1:0] region_first_block;
		logic [RBC_W-1:0] region_block_count;
		logic [CNT_W-1:0] max_readable;
	} cfg_t;

	function automatic logic [ADDR_W-1:0] blk_addr(input logic [NXT_W-1:0] blk);
		logic [ADDR_W+NXT_W-1:0] w;
		w = (ADDR_W + NXT_W)'(blk) << BLOCK_SHIFT;
		return w[ADDR_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] rec_bytes(input logic [CF_W-1:0] r);
		logic [ADDR_W+CF_W-1:0] w;
		w = (ADDR_W + CF_W)'(r) << REC_SHIFT;
		return w[ADDR_W-1:0];
	endfunction

endpackage

/* design/frlpm_fifo.sv */
module frlpm_fifo #(
	parameter type         T     = logic,
	parameter int unsigned DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(DEPTH + 1);

	T                  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (fill_q == FILL_W'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

/* design/frlpm_front.sv */
module frlpm_front #(
	parameter int unsigned DEPTH = frlpm_pkg::CMD_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  frlpm_pkg::item_t  item,
	output logic              full,
	input  logic              cmd_pop,
	output frlpm_pkg::cmd_t   cmd,
	output logic              cmd_empty
);

	import frlpm_pkg::*;

	cmd_t cls;

	always_comb begin
		cls.kind        = KIND_STATUS;
		cls.first_index = item.first_index;
		cls.read_count  = item.read_count;
		unique case (item.command)
			CMD_WRITE: begin
				// an empty record is skipped and only reports status
				cls.kind = item.record_is_empty ? KIND_STATUS : KIND_WRITE;
			end
			CMD_READ:  cls.kind = KIND_READ;
			CMD_CLEAR: cls.kind = KIND_CLEAR;
			CMD_QUERY: cls.kind = KIND_STATUS;
		endcase
	end

	frlpm_fifo #(
		.T     (cmd_t),
		.DEPTH (DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd),
		.empty  (cmd_empty)
	);

endmodule

/* design/frlpm_back.sv */
module frlpm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  frlpm_pkg::cfg_t     cfg,
	input  frlpm_pkg::cmd_t     cmd,
	input  logic                cmd_empty,
	output logic                cmd_pop,
	input  logic                res_full,
	output logic                res_push,
	output frlpm_pkg::result_t  res_data
);

	import frlpm_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PREP  = 6'b000010,
		ST_EXEC  = 6'b000100,
		ST_COUNT = 6'b001000,
		ST_ADDR  = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic              last;
	} seg_t;

	localparam logic [ADDR_W-1:0] WP_RESET   = blk_addr(NXT_W'(RFB_RESET));
	localparam seg_t              SEG_STATUS = '{OP_NONE, '0, LEN_W'(1), 1'b1};

	state_t            state_q;
	logic              sel_q;
	logic [ADDR_W-1:0] wp_q;
	logic [CNT_W-1:0]  saved_q;

	cmd_t              cmd_q;
	logic [CNT_W-1:0]  n_q;
	logic [ADDR_W-1:0] first_add_q;
	logic [ADDR_W-1:0] last_add_q;
	logic [FF_W-1:0]   ff_q;
	logic [ADDR_W-1:0] wp_sum_q;
	logic [CNT_W-1:0]  inc_q;
	logic              beyond_q;
	logic [CNT_W-1:0]  after_q;
	logic [LEN_W-1:0]  req_c_q;
	logic              far_q;
	logic [CF_W-1:0]   remain_q;
	logic [ADDR_W-1:0] near_q;
	logic [CNT_W-1:0]  cnt_q;
	seg_t              seg0_q;
	seg_t              seg1_q;
	logic              two_q;

	logic [CNT_W-1:0]  n_w;
	logic [NXT_W-1:0]  rfb_w;
	logic [NXT_W-1:0]  lim_w;
	logic [ADDR_W-1:0] first_add_w;
	logic [ADDR_W-1:0] diff_w;
	logic [FF_W-1:0]   ff_w;
	logic [NXT_W-1:0]  next_w;
	logic              boundary_w;
	logic              wrap_w;
	logic [ADDR_W-1:0] new_wp_w;
	logic              trim_w;
	logic [CNT_W-1:0]  saved_new_w;
	logic [CNT_W-1:0]  after_w;
	logic [CNT_W-1:0]  avail_w;
	logic [ADDR_W-1:0] far_addr_w;
	logic              emit_done;
	seg_t              seg_out;

	// ---- prep: readable count, region bounds, pointer offset, increments
	assign n_w         = (saved_q > cfg.max_readable) ? cfg.max_readable : saved_q;
	assign rfb_w       = NXT_W'(cfg.region_first_block);
	assign lim_w       = rfb_w + NXT_W'(cfg.region_block_count);
	assign first_add_w = blk_addr(rfb_w);
	assign diff_w      = wp_q - first_add_w;
	assign ff_w        = (wp_q >= first_add_w) ? diff_w[ADDR_W-1:REC_SHIFT] : '0;

	// ---- exec: write boundary handling
	assign boundary_w  = (wp_sum_q[BLOCK_SHIFT-1:0] == '0);
	assign next_w      = NXT_W'(wp_q[ADDR_W-1:BLOCK_SHIFT]) + NXT_W'(1);
	assign wrap_w      = (cfg.region_block_count == '0) || (next_w >= lim_w);
	assign new_wp_w    = blk_addr(wrap_w ? rfb_w : next_w);
	// region full: drop the oldest block's records
	assign trim_w      = (TRIM_W'(inc_q) == (TRIM_W'(cfg.region_block_count) << RPB_SHIFT));
	assign saved_new_w = trim_w ? inc_q - CNT_W'(RECORDS_PER_BLOCK) : inc_q;

	// ---- exec: read clipping
	assign after_w     = n_q - cmd_q.first_index;
	assign avail_w     = after_w + CNT_W'(1);

	// ---- addr: segment before the wrap ends at region end
	assign far_addr_w  = last_add_q - rec_bytes(remain_q);

	assign emit_done = (state_q == ST_EMIT) && !res_full && !(!sel_q && two_q);
	assign cmd_pop   = !cmd_empty && ((state_q == ST_IDLE) || emit_done);
	assign res_push  = (state_q == ST_EMIT) && !res_full;

	assign seg_out  = sel_q ? seg1_q : seg0_q;
	assign res_data = '{seg_out.op, seg_out.addr, seg_out.len, cnt_q, seg_out.last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
			wp_q    <= WP_RESET;
			saved_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_EXEC;
				ST_EXEC: begin
					state_q <= ST_COUNT;
					if (cmd_q.kind == KIND_CLEAR) begin
						wp_q    <= first_add_q;
						saved_q <= '0;
					end else if (cmd_q.kind == KIND_WRITE) begin
						if (boundary_w) begin
							wp_q    <= new_wp_w;
							saved_q <= saved_new_w;
						end else begin
							wp_q    <= wp_sum_q;
							saved_q <= inc_q;
						end
					end
				end
				ST_COUNT: state_q <= (cmd_q.kind == KIND_READ) ? ST_ADDR : ST_EMIT;
				ST_ADDR:  state_q <= ST_EMIT;
				ST_EMIT: begin
					if (!res_full) begin
						if (!sel_q && two_q) begin
							sel_q <= 1'b1;
						end else begin
							sel_q   <= 1'b0;
							state_q <= cmd_empty ? ST_IDLE : ST_PREP;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_PREP) begin
			n_q         <= n_w;
			first_add_q <= first_add_w;
			last_add_q  <= blk_addr(lim_w);
			ff_q        <= ff_w;
			wp_sum_q    <= wp_q + ADDR_W'(RECORD_BYTES);
			inc_q       <= (saved_q == CNT_MAX) ? saved_q : saved_q + CNT_W'(1);
		end
		if (state_q == ST_EXEC) begin
			beyond_q <= (cmd_q.first_index == '0) || (cmd_q.first_index > n_q);
			after_q  <= after_w;
			req_c_q  <= (CNT_W'(cmd_q.read_count) > avail_w) ? avail_w[LEN_W-1:0] :
				cmd_q.read_count;
			far_q    <= (CF_W'(after_w) > CF_W'(ff_q));
			unique case (cmd_q.kind)
				KIND_STATUS: begin
					seg0_q <= SEG_STATUS;
					two_q  <= 1'b0;
				end
				KIND_CLEAR: begin
					seg0_q <= '{OP_ERASE, first_add_q, LEN_W'(cfg.region_block_count), 1'b1};
					two_q  <= 1'b0;
				end
				KIND_WRITE: begin
					seg0_q <= '{OP_PROGRAM, wp_q, LEN_W'(1), !boundary_w};
					seg1_q <= '{OP_ERASE, new_wp_w, LEN_W'(1), 1'b1};
					two_q  <= boundary_w;
				end
				KIND_READ: begin
					two_q <= 1'b0;
				end
			endcase
		end
		if (state_q == ST_COUNT) begin
			cnt_q    <= n_w;
			remain_q <= CF_W'(after_q) - CF_W'(ff_q) + CF_W'(1);
			near_q   <= wp_q - rec_bytes(CF_W'(after_q) + CF_W'(1));
		end
		if (state_q == ST_ADDR) begin
			if (beyond_q || (req_c_q == '0)) begin
				seg0_q <= SEG_STATUS;
				two_q  <= 1'b0;
			end else if (far_q) begin
				if (remain_q >= CF_W'(req_c_q)) begin
					seg0_q <= '{OP_READ, far_addr_w, req_c_q, 1'b1};
					two_q  <= 1'b0;
				end else begin
					// split at the region's wrap
					seg0_q <= '{OP_READ, far_addr_w, remain_q[LEN_W-1:0], 1'b0};
					seg1_q <= '{OP_READ, first_add_q, req_c_q - remain_q[LEN_W-1:0], 1'b1};
					two_q  <= 1'b1;
				end
			end else begin
				seg0_q <= '{OP_READ, near_q, req_c_q, 1'b1};
				two_q  <= 1'b0;
			end
		end
	end

endmodule

/* design/flash_ring_log_pointer_manager_core.sv */
// Channel   Handshake              Payload
// -------   ---------------------  -----------------------------------
// request   push / full            item   (command, index, count)
// result    empty / pop            result (flash op, address, length, count, last)
// config    cfg_wr_en, cfg_index   cfg_wr_data, no stall, no read-back
//
// A request passes the back-end sequencer states prep, exec, count and emit (write,
// clear, query), with addr added for a read, emit again for a second result and idle
// first when starting from idle; it runs one request at a time and sets the rate.
// Requests queue ahead of the sequencer, results queue behind it, so either
// side may stall without blocking the other until its queue fills.
// Reset clears the pointer to the region start and the stored count to zero.
module flash_ring_log_pointer_manager_core #(
	parameter int unsigned CMD_DEPTH = frlpm_pkg::CMD_DEPTH_DEF,
	parameter int unsigned RES_DEPTH = frlpm_pkg::RES_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	input  frlpm_pkg::item_t                      item,
	output logic                                  full,
	output logic                                  empty,
	input  logic                                  pop,
	output frlpm_pkg::result_t                    result,
	input  logic                                  cfg_wr_en,
	input  logic [frlpm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [frlpm_pkg::CFG_W-1:0]           cfg_wr_data
);

	import frlpm_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	logic    cmd_empty;
	logic    cmd_pop;
	logic    res_full;
	logic    res_push;
	result_t res_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_first_block <= RFB_RESET;
			cfg_q.region_block_count <= RBC_RESET;
			cfg_q.max_readable       <= MAX_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FIRST_BLOCK:  cfg_q.region_first_block <= cfg_wr_data[RFB_W-1:0];
				REG_BLOCK_COUNT:  cfg_q.region_block_count <= cfg_wr_data[RBC_W-1:0];
				REG_MAX_READABLE: cfg_q.max_readable       <= cfg_wr_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	frlpm_front #(
		.DEPTH (CMD_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.cmd_empty (cmd_empty)
	);

	frlpm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	frlpm_fifo #(
		.T     (result_t),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

`ifndef ASSERT_OFF
	// an erase always closes its request
	a_erase_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && (res_data.flash_op == OP_ERASE) |-> res_data.last)
		else $error("erase result not marked last");

	// no new request is fetched while its predecessor still has results to give
	a_no_fetch_mid: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && !res_data.last |-> !cmd_pop)
		else $error("request fetched before last result");

	// an accepted request is visible to the back end on the next cycle
	a_req_queued: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> !cmd_empty)
		else $error("accepted request lost");
`endif

endmodule

/* verif/flash_ring_log_pointer_manager_core_tb.sv */
`timescale 1ns / 100ps

module flash_ring_log_pointer_manager_core_tb;
	import frlpm_pkg::*;

	localparam longint unsigned ADDR_SPAN = 64'hFF_FFFF;
	localparam int unsigned RUN_LIMIT = 4_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	item_t item = '0;
	logic full;
	logic empty;
	logic pop = 1'b0;
	result_t result;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wr_data = '0;

	flash_ring_log_pointer_manager_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the registers and the log state
	logic [RFB_W-1:0] cf_first = RFB_RESET;
	logic [RBC_W-1:0] cf_count = RBC_RESET;
	logic [CNT_W-1:0] cf_max = MAX_RESET;
	logic [ADDR_W-1:0] wr_ptr = '0;
	logic [CNT_W-1:0] rec_total = '0;

	result_t pending_ops[$];
	int mismatches = 0;
	int requests_sent = 0;
	int ops_checked = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_len = 0;
	int unsigned cycle_count = 0;

	function automatic logic [CNT_W-1:0] readable_now();
		return (rec_total > cf_max) ? cf_max : rec_total;
	endfunction

	task automatic queue_op(input logic [1:0] op, input longint unsigned addr,
			input longint unsigned len, input logic fin);
		result_t r;
		r.flash_op = op;
		r.flash_address = addr[ADDR_W-1:0];
		r.op_length = len[LEN_W-1:0];
		r.stored_count = readable_now();
		r.last = fin;
		pending_ops.push_back(r);
	endtask

	task automatic predict_flash_ops(input item_t req);
		longint unsigned prog, nxt, first_add, last_add, n, start, want, after, from_first;
		longint unsigned remain, addr;
		first_add = (longint'(cf_first) << BLOCK_SHIFT) & ADDR_SPAN;
		last_add = ((longint'(cf_first) + longint'(cf_count)) << BLOCK_SHIFT) & ADDR_SPAN;
		case (req.command)
		CMD_WRITE: begin
			if (req.record_is_empty) begin
				queue_op(OP_NONE, 0, 1, 1'b1);
			end else begin
				prog = 64'(wr_ptr);
				wr_ptr = wr_ptr + ADDR_W'(RECORD_BYTES);
				if (rec_total != CNT_MAX)
					rec_total++;
				if (wr_ptr[BLOCK_SHIFT-1:0] != '0) begin
					queue_op(OP_PROGRAM, prog, 1, 1'b1);
				end else begin
					// crossed into the next block: erase ahead, wrap inside region
					nxt = (prog >> BLOCK_SHIFT) + 1;
					if (cf_count == 0 || nxt > 64'(cf_first) + 64'(cf_count) - 1)
						nxt = 64'(cf_first);
					wr_ptr = ADDR_W'((nxt << BLOCK_SHIFT) & ADDR_SPAN);
					if (longint'(rec_total) == longint'(cf_count) * RECORDS_PER_BLOCK)
						rec_total = rec_total - CNT_W'(RECORDS_PER_BLOCK);
					queue_op(OP_PROGRAM, prog, 1, 1'b0);
					queue_op(OP_ERASE, 64'(wr_ptr), 1, 1'b1);
				end
			end
		end
		CMD_READ: begin
			n = 64'(readable_now());
			start = 64'(req.first_index);
			want = 64'(req.read_count);
			if (start == 0 || start > n) begin
				queue_op(OP_NONE, 0, 1, 1'b1);
			end else begin
				if (want > n - start + 1)
					want = n - start + 1;
				if (want == 0) begin
					queue_op(OP_NONE, 0, 1, 1'b1);
				end else begin
					after = n - start;
					from_first = (64'(wr_ptr) >= first_add) ?
						(64'(wr_ptr) - first_add) / RECORD_BYTES : 0;
					if (after > from_first) begin
						// oldest part sits at the top of the region
						remain = after - from_first + 1;
						addr = (last_add - remain * RECORD_BYTES) & ADDR_SPAN;
						if (remain >= want) begin
							queue_op(OP_READ, addr, want, 1'b1);
						end else begin
							queue_op(OP_READ, addr, remain, 1'b0);
							queue_op(OP_READ, first_add, want - remain, 1'b1);
						end
					end else begin
						addr = (64'(wr_ptr) - (after + 1) * RECORD_BYTES) & ADDR_SPAN;
						queue_op(OP_READ, addr, want, 1'b1);
					end
				end
			end
		end
		CMD_CLEAR: begin
			wr_ptr = first_add[ADDR_W-1:0];
			rec_total = '0;
			queue_op(OP_ERASE, 64'(wr_ptr), 64'(cf_count), 1'b1);
		end
		default: begin
			queue_op(OP_NONE, 0, 1, 1'b1);
		end
		endcase
	endtask

	function automatic item_t request_of(input logic [1:0] cmd, input logic skip,
			input logic [CNT_W-1:0] fi, input logic [LEN_W-1:0] cnt);
		item_t r;
		r.command = cmd;
		r.record_is_empty = skip;
		r.first_index = fi;
		r.read_count = cnt;
		return r;
	endfunction

	function automatic item_t random_read();
		logic [CNT_W-1:0] fi;
		logic [LEN_W-1:0] cnt;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		fi = (pick < 80) ? CNT_W'($urandom_range(0, readable_now() + 2)) : CNT_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 70)
			cnt = LEN_W'($urandom_range(0, 64));
		else if (pick < 90)
			cnt = LEN_W'($urandom_range(0, RECORDS_PER_BLOCK));
		else
			cnt = LEN_W'($urandom);
		return request_of(CMD_READ, 1'($urandom), fi, cnt);
	endfunction

	function automatic item_t random_request();
		item_t r;
		int unsigned pick;
		r.command = CMD_QUERY;
		r.record_is_empty = 1'($urandom);
		r.first_index = CNT_W'($urandom);
		r.read_count = LEN_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			r.command = CMD_WRITE;
			r.record_is_empty = ($urandom_range(0, 7) == 0);
		end else if (pick < 80) begin
			r = random_read();
		end else if (pick < 85) begin
			r.command = CMD_CLEAR;
		end else begin
			r.command = CMD_QUERY;
		end
		return r;
	endfunction

	task automatic offer(input item_t req);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= req;
		do @(posedge clk); while (full);
		requests_sent++;
		predict_flash_ops(req);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_ops.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_region(input logic [RFB_W-1:0] fb, input logic [RBC_W-1:0] bc,
			input logic [CNT_W-1:0] mx);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_FIRST_BLOCK;
		cfg_wr_data <= CFG_W'(fb);
		@(posedge clk);
		cfg_index <= REG_BLOCK_COUNT;
		cfg_wr_data <= CFG_W'(bc);
		@(posedge clk);
		cfg_index <= REG_MAX_READABLE;
		cfg_wr_data <= mx;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cf_first = fb;
		cf_count = bc;
		cf_max = mx;
	endtask

	task automatic report_field(input string name, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		mismatches++;
		$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
	endtask

	task automatic check_flash_op(input result_t got);
		result_t want;
		if (pending_ops.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result, expected none actual %p", $time, got);
			return;
		end
		want = pending_ops.pop_front();
		ops_checked++;
		if (got.flash_op !== want.flash_op)
			report_field("flash_op", ADDR_W'(want.flash_op), ADDR_W'(got.flash_op));
		if (got.flash_address !== want.flash_address)
			report_field("flash_address", want.flash_address, got.flash_address);
		if (got.op_length !== want.op_length)
			report_field("op_length", ADDR_W'(want.op_length), ADDR_W'(got.op_length));
		if (got.stored_count !== want.stored_count)
			report_field("stored_count", ADDR_W'(want.stored_count),
				ADDR_W'(got.stored_count));
		if (got.last !== want.last)
			report_field("last", ADDR_W'(want.last), ADDR_W'(got.last));
	endtask

	// result side: check on accept, then pick next pop (long hold first)
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_flash_op(result);
			if (stall_len > 0) begin
				stall_len--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_directed();
		send_idle_pct = 19;
		recv_idle_pct = 51;
		offer(request_of(CMD_QUERY, 1'b0, '0, '0));
		offer(request_of(CMD_READ, 1'b0, 17'd1, 13'd1));      // nothing stored yet
		offer(request_of(CMD_WRITE, 1'b1, '0, '0));           // skipped record
		repeat (3) offer(request_of(CMD_WRITE, 1'b0, '1, '1));
		offer(request_of(CMD_READ, 1'b0, 17'd0, 13'd3));
		offer(request_of(CMD_READ, 1'b0, 17'd1, 13'd0));
		offer(request_of(CMD_READ, 1'b0, 17'd2, 13'h1FFF));   // clipped to count
		offer(request_of(CMD_READ, 1'b0, 17'd3, 13'd1));
		offer(request_of(CMD_READ, 1'b1, 17'h1FFFF, 13'd4096));
		offer(request_of(CMD_CLEAR, 1'b0, '0, '0));
		offer(request_of(CMD_QUERY, 1'b1, '1, '1));

		program_region(8'hFF, 5'd16, 17'd0);
		offer(request_of(CMD_CLEAR, 1'b0, '0, '0));
		repeat (2) offer(request_of(CMD_WRITE, 1'b0, '0, '0));
		offer(request_of(CMD_READ, 1'b0, 17'd1, 13'd1));      // cap of zero hides all
		program_region(8'hFF, 5'd31, 17'h1FFFF);
		offer(request_of(CMD_READ, 1'b0, 17'd1, 13'd2));

		// pointer left below the region after moving it up
		program_region(8'd3, 5'd2, 17'h1FFFF);
		offer(request_of(CMD_CLEAR, 1'b0, '0, '0));
		repeat (3) offer(request_of(CMD_WRITE, 1'b0, '0, '0));
		program_region(8'd200, 5'd2, 17'd2);
		offer(request_of(CMD_READ, 1'b0, 17'd1, 13'd10));
		offer(request_of(CMD_READ, 1'b0, 17'd2, 13'd1));
		drain();
	endtask

	task automatic test_backpressure();
		int k;
		drain();
		stall_len = 300;
		for (k = 0; k < 40; k++)
			offer(random_request());
		drain();
	endtask

	task automatic random_region();
		logic [RFB_W-1:0] fb;
		logic [RBC_W-1:0] bc;
		logic [CNT_W-1:0] mx;
		case ($urandom_range(0, 2))
		0: fb = '0;
		1: fb = '1;
		default: fb = RFB_W'($urandom);
		endcase
		bc = ($urandom_range(0, 9) < 7) ? RBC_W'($urandom_range(2, 16)) : RBC_W'($urandom);
		case ($urandom_range(0, 4))
		0: mx = '0;
		1: mx = 17'd65536;
		2: mx = '1;
		3: mx = MAX_RESET;
		default: mx = CNT_W'($urandom);
		endcase
		program_region(fb, bc, mx);
	endtask

	task automatic test_random_mix();
		int ph, blk, k;
		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 51 : 0;
			recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 19 : 0;
			for (blk = 0; blk < 3; blk++) begin
				random_region();
				for (k = 0; k < 130; k++)
					offer(random_request());
			end
		end
		drain();
	endtask

	initial begin
		int waited;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random_mix();

		push <= 1'b0;
		waited = 0;
		while (pending_ops.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pending_ops.size() != 0) begin
			mismatches += pending_ops.size();
			$display("%0t: %0d expected results never arrived", $time, pending_ops.size());
		end

		$display("Sent %0d requests, checked %0d flash ops over directed cases, a long",
			requests_sent, ops_checked);
		$display("result stall and random traffic across reprogrammed regions and caps.");
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
